// ===== hw/rtl/transposition_table_probe_store_macros.svh =====
// Assertion macros shared by the transposition table RTL.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TTPS_ASSERT_IMP(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ttps same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TTPS_ASSERT_NEXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ttps next-cycle check failed");

`endif

// ===== hw/rtl/ttps_pkg.sv =====
// Types, constants and helper functions of the transposition table.
`default_nettype none

package ttps_pkg;

	localparam int INDEX_BITS = 10;
	localparam int HASH_BITS  = 32;
	localparam int TT_ENTRIES = 1 << INDEX_BITS;
	localparam int TAG_W      = (HASH_BITS > INDEX_BITS) ? HASH_BITS - INDEX_BITS : 1;
	localparam int DEPTH_W    = 6;
	localparam int MATE_WINDOW = 100;
	localparam int CFG_IDX_W  = 1;

	localparam logic [14:0]        MATE_RESET  = 15'd30000;
	localparam logic signed [15:0] MATED_RESET = -16'sd30000;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [TAG_W-1:0]      tag_t;

	typedef enum logic [1:0] {
		OP_PROBE      = 2'd0,
		OP_STORE      = 2'd1,
		OP_PROBE_MOVE = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BOUND_EXACT = 2'd0,
		BOUND_UPPER = 2'd1,
		BOUND_LOWER = 2'd2,
		BOUND_NONE  = 2'd3
	} bound_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATE_SCORE  = 1'd0,
		REG_MATED_SCORE = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]         flags;
		logic [7:0]         to_sq;
		logic [7:0]         from_sq;
		bound_t             bound;
		logic [DEPTH_W-1:0] depth;
		logic signed [15:0] score;
	} entry_t;

	typedef struct packed {
		tag_t   tag;
		entry_t entry;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	function automatic index_t hash_index(input logic [HASH_BITS-1:0] h);
		index_t r;
		r = '0;
		for (int i = 0; i < INDEX_BITS; i++) begin
			if (i < HASH_BITS) begin
				r[i] = h[i];
			end
		end
		return r;
	endfunction

	// Tag is the hash above the index bits; zero when the index eats the whole hash.
	function automatic tag_t hash_tag(input logic [HASH_BITS-1:0] h);
		tag_t r;
		r = '0;
		for (int i = 0; i < TAG_W; i++) begin
			if (i + INDEX_BITS < HASH_BITS) begin
				r[i] = h[i + INDEX_BITS];
			end
		end
		return r;
	endfunction

	// Shift mate scores by ply: away from zero toward storage, back on the way out.
	function automatic logic signed [15:0] mate_adjust(
		input logic signed [15:0] s,
		input logic [7:0]         ply,
		input logic               to_store,
		input logic [14:0]        mate,
		input logic signed [15:0] mated
	);
		logic signed [17:0] mate_lim;
		logic signed [17:0] mated_lim;
		logic signed [17:0] s_x;
		logic [15:0]        s_u;
		logic [15:0]        ply_x;
		logic [15:0]        r;
		mate_lim  = $signed({3'b000, mate}) - 18'(MATE_WINDOW);
		mated_lim = $signed({{2{mated[15]}}, mated}) + 18'(MATE_WINDOW);
		s_x   = $signed({{2{s[15]}}, s});
		s_u   = s;
		ply_x = {8'd0, ply};
		r     = s_u;
		if (s_x > mate_lim) begin
			r = to_store ? s_u + ply_x : s_u - ply_x;
		end else if (s_x < mated_lim) begin
			r = to_store ? s_u - ply_x : s_u + ply_x;
		end
		return $signed(r);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ttps_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ttps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/transposition_table_probe_store.sv =====
// Top level of the direct-mapped transposition table with always-replace stores.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | op hash depth alpha beta score bound move ply
//  out     | out_valid / out_ready  | hit tag_match result_score best_from/to/flags
//  cfg     | cfg_valid / cfg_ready  | cfg_index cfg_data (cfg_ready is always high)
//
// One request a cycle while in_ready is high: accept issues the RAM read, stage 1
// evaluates the row, and the result register presents it on out_valid.
// Reset and every clear request walk all TT_ENTRIES rows through the RAM write
// port, one row a cycle, with in_ready low; cfg writes still land.
// A stalled result holds stage 1 and the read data; with both full, in_ready follows out_ready.
`default_nettype none
`include "transposition_table_probe_store_macros.svh"

module transposition_table_probe_store (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         op,
	input  wire logic [ttps_pkg::HASH_BITS-1:0]     hash,
	input  wire logic [7:0]                         depth,
	input  wire logic signed [15:0]                 alpha,
	input  wire logic signed [15:0]                 beta,
	input  wire logic signed [15:0]                 score,
	input  wire logic [1:0]                         bound,
	input  wire logic [7:0]                         move_from,
	input  wire logic [7:0]                         move_to,
	input  wire logic [7:0]                         move_flags,
	input  wire logic [7:0]                         ply,

	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    hit,
	output logic                                    tag_match,
	output logic signed [15:0]                      result_score,
	output logic [7:0]                              best_from,
	output logic [7:0]                              best_to,
	output logic [7:0]                              best_flags,

	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ttps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                        cfg_data
);

	import ttps_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_CLEAR = 2'b10
	} state_t;

	typedef struct packed {
		op_t                op;
		tag_t               tag;
		logic [7:0]         depth;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [7:0]         ply;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic               tag_match;
		logic signed [15:0] score;
		logic [7:0]         from_sq;
		logic [7:0]         to_sq;
		logic [7:0]         flags;
	} res_t;

	state_t             state_q;
	index_t             clr_cnt_q;
	logic [14:0]        mate_q;
	logic signed [15:0] mated_q;

	logic               valid_s1;
	req_t               req_s1;
	logic               out_valid_q;
	res_t               res_q;

	logic               in_acc;
	logic               adv_s1;
	op_t                op_in;
	index_t             idx_in;
	logic               ram_we;
	index_t             ram_waddr;
	row_t               wr_row;
	logic [ROW_W-1:0]   rdata;
	row_t               rd_row;
	logic signed [15:0] adj_score;
	logic               deep_enough;
	logic               cut;
	logic signed [15:0] cut_score;
	res_t               res_d;

	assign op_in     = op_t'(op);
	assign idx_in    = hash_index(hash);
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_RUN) && (!valid_s1 || adv_s1);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Write port: clearing walk, else a store at its accept.
	always_comb begin
		wr_row               = '0;
		wr_row.tag           = hash_tag(hash);
		wr_row.entry.score   = mate_adjust(score, ply, 1'b1, mate_q, mated_q);
		wr_row.entry.depth   = depth[DEPTH_W-1:0];
		wr_row.entry.bound   = bound_t'(bound);
		wr_row.entry.from_sq = move_from;
		wr_row.entry.to_sq   = move_to;
		wr_row.entry.flags   = move_flags;
		ram_we    = in_acc && (op_in == OP_STORE);
		ram_waddr = idx_in;
		if (state_q == ST_CLEAR) begin
			wr_row    = '0;
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end
	end

	ttps_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TT_ENTRIES)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_row),
		.re    (in_acc),
		.raddr (idx_in),
		.rdata (rdata)
	);

	assign rd_row      = row_t'(rdata);
	assign adj_score   = mate_adjust(rd_row.entry.score, req_s1.ply, 1'b0, mate_q, mated_q);
	assign deep_enough = {2'b00, rd_row.entry.depth} >= req_s1.depth;

	always_comb begin
		cut       = 1'b0;
		cut_score = '0;
		unique case (rd_row.entry.bound)
			BOUND_EXACT: begin
				cut       = 1'b1;
				cut_score = adj_score;
			end
			BOUND_UPPER: begin
				if (adj_score <= req_s1.alpha) begin
					cut       = 1'b1;
					cut_score = req_s1.alpha;
				end
			end
			BOUND_LOWER: begin
				if (adj_score >= req_s1.beta) begin
					cut       = 1'b1;
					cut_score = req_s1.beta;
				end
			end
			BOUND_NONE: begin
				cut = 1'b0;
			end
		endcase
		if (!deep_enough) begin
			cut       = 1'b0;
			cut_score = '0;
		end
	end

	always_comb begin
		res_d = '0;
		unique case (req_s1.op)
			OP_PROBE, OP_PROBE_MOVE: begin
				if (rd_row.tag == req_s1.tag) begin
					res_d.tag_match = 1'b1;
					res_d.from_sq   = rd_row.entry.from_sq;
					res_d.to_sq     = rd_row.entry.to_sq;
					res_d.flags     = rd_row.entry.flags;
					if (req_s1.op == OP_PROBE) begin
						res_d.hit   = cut;
						res_d.score = cut_score;
					end else begin
						res_d.hit = (rd_row.entry.from_sq != 8'd0)
							|| (rd_row.entry.to_sq != 8'd0);
					end
				end
			end
			OP_STORE, OP_CLEAR: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (in_acc && (op_in == OP_CLEAR)) begin
						state_q   <= ST_CLEAR;
						clr_cnt_q <= '0;
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q  <= MATE_RESET;
			mated_q <= MATED_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MATE_SCORE:  mate_q  <= cfg_data[14:0];
				REG_MATED_SCORE: mated_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: capture the request at accept, the result on advance.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1.op    <= op_in;
			req_s1.tag   <= hash_tag(hash);
			req_s1.depth <= depth;
			req_s1.alpha <= alpha;
			req_s1.beta  <= beta;
			req_s1.ply   <= ply;
		end
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = res_q.hit;
	assign tag_match    = res_q.tag_match;
	assign result_score = res_q.score;
	assign best_from    = res_q.from_sq;
	assign best_to      = res_q.to_sq;
	assign best_flags   = res_q.flags;

	`TTPS_ASSERT_NEXT(a_clear_starts, clk, arst_n, in_acc && (op_in == OP_CLEAR), (state_q == ST_CLEAR) && (clr_cnt_q == '0))
	`TTPS_ASSERT_NEXT(a_clear_walks, clk, arst_n, (state_q == ST_CLEAR) && (clr_cnt_q != '1), (state_q == ST_CLEAR) && (clr_cnt_q == $past(clr_cnt_q) + 1'b1))
	`TTPS_ASSERT_NEXT(a_stall_holds_row, clk, arst_n, valid_s1 && out_valid_q && !out_ready, valid_s1 && $stable(rdata))

endmodule

`default_nettype wire
